### sv/bupd_pkg.sv
package bupd_pkg;

   localparam int DIM_W   = 16;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic       KIND_PIXEL = 1'b0;
   localparam logic       KIND_ERROR = 1'b1;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SHORT = 2'd1;
   localparam logic [1:0] ERR_UNSUP = 2'd2;
   localparam logic [1:0] ERR_TRUNC = 2'd3;

   localparam logic [31:0] HDR_LAST    = 32'd53;
   localparam logic [31:0] PIXEL_START = 32'd54;

   typedef enum logic [1:0] {
      FR_HEADER,
      FR_SKIP,
      FR_STREAM,
      FR_DRAIN
   } fr_phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PIXELS,
      BK_DONE
   } bk_state_type;

   typedef enum logic [1:0] {
      TK_START,
      TK_DATA,
      TK_ERROR
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type     kind;
      logic [1:0]       code;
      logic [7:0]       data;
      logic             eof;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             bpp32;
   } token_type;

endpackage

### sv/bupd_front.sv
module bupd_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_file,
   output logic                push,
   output bupd_pkg::token_type push_token
);
   import bupd_pkg::*;

   fr_phase_type phase_ff, phase_in;
   logic [31:0]  pos_ff, pos_in;
   logic [31:0]  off_ff, off_in;
   logic [31:0]  wid_ff, wid_in;
   logic [31:0]  hgt_ff, hgt_in;
   logic [3:0]   chk_ff, chk_in;   // planes, bc24, bc32, no compression

   logic         accept;
   logic         hdr_ok;
   logic [1:0]   byte_idx;

   assign accept = req_valid && !req_stall;

   assign hdr_ok = chk_ff[0] && chk_ff[3] && (chk_ff[1] || chk_ff[2]) &&
                   (wid_ff != 32'd0) && (wid_ff <= 32'(MAX_WIDTH)) &&
                   (hgt_ff != 32'd0) && (hgt_ff <= 32'(MAX_HEIGHT));

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      off_in     = off_ff;
      wid_in     = wid_ff;
      hgt_in     = hgt_ff;
      chk_in     = chk_ff;
      push       = 1'b0;
      byte_idx   = 2'd0;
      push_token = '{kind: TK_DATA, code: ERR_NONE, data: req_data_byte,
                     eof: req_end_of_file, width: wid_ff[DIM_W-1:0],
                     height: hgt_ff[DIM_W-1:0], bpp32: chk_ff[2]};
      if (accept) begin
         case (phase_ff)
            FR_HEADER: begin
               case (pos_ff) inside
                  [32'd10:32'd13]: begin
                     byte_idx = 2'(pos_ff - 32'd10);
                     off_in[8*byte_idx +: 8] = req_data_byte;
                  end
                  [32'd18:32'd21]: begin
                     byte_idx = 2'(pos_ff - 32'd18);
                     wid_in[8*byte_idx +: 8] = req_data_byte;
                  end
                  [32'd22:32'd25]: begin
                     byte_idx = 2'(pos_ff - 32'd22);
                     hgt_in[8*byte_idx +: 8] = req_data_byte;
                  end
                  32'd26: if (req_data_byte == 8'd1) chk_in[0] = 1'b1;
                  32'd27: if (req_data_byte != 8'd0) chk_in[0] = 1'b0;
                  32'd28: begin
                     if (req_data_byte == 8'd24) chk_in[1] = 1'b1;
                     if (req_data_byte == 8'd32) chk_in[2] = 1'b1;
                  end
                  32'd29: if (req_data_byte != 8'd0) chk_in[2:1] = 2'b00;
                  32'd30: if (req_data_byte == 8'd0) chk_in[3] = 1'b1;
                  [32'd31:32'd33]: if (req_data_byte != 8'd0) chk_in[3] = 1'b0;
                  default: ;
               endcase
               if (pos_ff == HDR_LAST) begin
                  push = 1'b1;
                  if (!hdr_ok) begin
                     push_token.kind = TK_ERROR;
                     push_token.code = ERR_UNSUP;
                     phase_in        = FR_DRAIN;
                  end else begin
                     phase_in = (off_ff > PIXEL_START) ? FR_SKIP : FR_STREAM;
                     if (req_end_of_file) begin
                        push_token.kind = TK_ERROR;
                        push_token.code = ERR_TRUNC;
                     end else begin
                        push_token.kind = TK_START;
                     end
                  end
               end else if (req_end_of_file) begin
                  push            = 1'b1;
                  push_token.kind = TK_ERROR;
                  push_token.code = ERR_SHORT;
               end
            end
            FR_SKIP: begin
               if ((33'(pos_ff) + 33'd1 >= 33'(off_ff)) || (pos_ff == '1))
                  phase_in = FR_STREAM;
               if (req_end_of_file) begin
                  push            = 1'b1;
                  push_token.kind = TK_ERROR;
                  push_token.code = ERR_TRUNC;
               end
            end
            FR_STREAM: push = 1'b1;
            default: ;
         endcase
         if (pos_ff != '1)
            pos_in = pos_ff + 32'd1;
         // end of file: ready for the next file
         if (req_end_of_file) begin
            phase_in = FR_HEADER;
            pos_in   = '0;
            off_in   = '0;
            wid_in   = '0;
            hgt_in   = '0;
            chk_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= FR_HEADER;
         pos_ff   <= '0;
         off_ff   <= '0;
         wid_ff   <= '0;
         hgt_ff   <= '0;
         chk_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         off_ff   <= off_in;
         wid_ff   <= wid_in;
         hgt_ff   <= hgt_in;
         chk_ff   <= chk_in;
      end
   end

endmodule

### sv/bupd_queue.sv
module bupd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bupd_pkg::token_type push_token,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output bupd_pkg::token_type head_token
);
   import bupd_pkg::*;

   token_type         mem [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem[wr_ptr_ff] <= push_token;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/bupd_back.sv
module bupd_back #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  bupd_pkg::token_type head_token,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [1:0]          rsp_error_code,
   output logic [11:0]         rsp_column,
   output logic [11:0]         rsp_row,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic [7:0]          rsp_alpha,
   output logic                rsp_has_alpha,
   output logic                rsp_last_pixel
);
   import bupd_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   bk_state_type  state_ff, state_in;
   logic [WW-1:0] wid_ff, wid_in;
   logic [HW-1:0] hgt_ff, hgt_in;
   logic          bpp32_ff, bpp32_in;
   logic [WW-1:0] col_ff, col_in;
   logic [HW-1:0] frow_ff, frow_in;
   logic [1:0]    bip_ff, bip_in;
   logic [1:0]    pad_ff, pad_in;
   logic [23:0]   pb_ff, pb_in;

   logic          valid_ff, valid_in;
   logic          kind_ff, kind_in;
   logic [1:0]    code_ff, code_in;
   logic [11:0]   column_ff, column_in;
   logic [11:0]   row_ff, row_in;
   logic [7:0]    red_ff, red_in;
   logic [7:0]    green_ff, green_in;
   logic [7:0]    blue_ff, blue_in;
   logic [7:0]    alpha_ff, alpha_in;
   logic          has_alpha_ff, has_alpha_in;
   logic          last_ff, last_in;

   logic          out_free;
   logic          pix_done;
   logic          row_end;
   logic          img_end;
   logic [23:0]   pb_next;
   logic [31:0]   col_ext;
   logic [31:0]   row_ext;

   assign out_free = !valid_ff || !rsp_stall;
   assign pop      = head_valid && out_free;

   assign row_end = (WW'(col_ff) + 1'b1 == wid_ff);
   assign img_end = row_end && (HW'(frow_ff) + 1'b1 == hgt_ff);
   assign col_ext = 32'(col_ff);
   assign row_ext = 32'(hgt_ff) - 32'd1 - 32'(frow_ff);

   always_comb begin
      pb_next = pb_ff;
      if (bip_ff != 2'd3)
         pb_next[8*bip_ff +: 8] = head_token.data;
   end

   always_comb begin
      state_in     = state_ff;
      wid_in       = wid_ff;
      hgt_in       = hgt_ff;
      bpp32_in     = bpp32_ff;
      col_in       = col_ff;
      frow_in      = frow_ff;
      bip_in       = bip_ff;
      pad_in       = pad_ff;
      pb_in        = pb_ff;
      valid_in     = valid_ff && rsp_stall;
      kind_in      = kind_ff;
      code_in      = code_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      alpha_in     = alpha_ff;
      has_alpha_in = has_alpha_ff;
      last_in      = last_ff;
      pix_done     = 1'b0;

      if (pop) begin
         case (head_token.kind)
            TK_START: begin
               state_in = BK_PIXELS;
               wid_in   = head_token.width[WW-1:0];
               hgt_in   = head_token.height[HW-1:0];
               bpp32_in = head_token.bpp32;
               col_in   = '0;
               frow_in  = '0;
               bip_in   = '0;
               pad_in   = '0;
               pb_in    = '0;
            end
            TK_DATA: begin
               if (state_ff == BK_PIXELS) begin
                  if (pad_ff != 2'd0) begin
                     pad_in = pad_ff - 2'd1;
                  end else if (bip_ff == (bpp32_ff ? 2'd3 : 2'd2)) begin
                     pix_done     = 1'b1;
                     valid_in     = 1'b1;
                     kind_in      = KIND_PIXEL;
                     code_in      = ERR_NONE;
                     column_in    = col_ext[11:0];
                     row_in       = row_ext[11:0];
                     red_in       = pb_next[23:16];
                     green_in     = pb_next[15:8];
                     blue_in      = pb_next[7:0];
                     alpha_in     = bpp32_ff ? head_token.data : 8'd0;
                     has_alpha_in = bpp32_ff;
                     last_in      = img_end;
                     bip_in       = '0;
                     pb_in        = '0;
                     if (img_end) begin
                        state_in = BK_DONE;
                     end else if (row_end) begin
                        col_in  = '0;
                        frow_in = frow_ff + 1'b1;
                        // 24-bit rows pad by width mod 4; 32-bit rows never pad
                        pad_in  = bpp32_ff ? 2'd0 : wid_ff[1:0];
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end else begin
                     bip_in = bip_ff + 2'd1;
                     pb_in  = pb_next;
                  end
                  // truncation replaces any pixel this word completes, except the image's last pixel
                  if (head_token.eof && !(pix_done && img_end)) begin
                     valid_in     = 1'b1;
                     kind_in      = KIND_ERROR;
                     code_in      = ERR_TRUNC;
                     column_in    = '0;
                     row_in       = '0;
                     red_in       = '0;
                     green_in     = '0;
                     blue_in      = '0;
                     alpha_in     = '0;
                     has_alpha_in = 1'b0;
                     last_in      = 1'b0;
                  end
               end
               if (head_token.eof)
                  state_in = BK_IDLE;
            end
            TK_ERROR: begin
               state_in     = BK_IDLE;
               valid_in     = 1'b1;
               kind_in      = KIND_ERROR;
               code_in      = head_token.code;
               column_in    = '0;
               row_in       = '0;
               red_in       = '0;
               green_in     = '0;
               blue_in      = '0;
               alpha_in     = '0;
               has_alpha_in = 1'b0;
               last_in      = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
         col_ff   <= '0;
         frow_ff  <= '0;
         bip_ff   <= '0;
         pad_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         col_ff   <= col_in;
         frow_ff  <= frow_in;
         bip_ff   <= bip_in;
         pad_ff   <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      wid_ff       <= wid_in;
      hgt_ff       <= hgt_in;
      bpp32_ff     <= bpp32_in;
      pb_ff        <= pb_in;
      kind_ff      <= kind_in;
      code_ff      <= code_in;
      column_ff    <= column_in;
      row_ff       <= row_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      alpha_ff     <= alpha_in;
      has_alpha_ff <= has_alpha_in;
      last_ff      <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_error_code  = code_ff;
   assign rsp_column      = column_ff;
   assign rsp_row         = row_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_alpha       = alpha_ff;
   assign rsp_has_alpha   = has_alpha_ff;
   assign rsp_last_pixel  = last_ff;

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_ERROR) |->
         (column_ff == '0 && row_ff == '0 && has_alpha_ff == 1'b0 && last_ff == 1'b0))
      else $error("error word carries pixel fields");

   a_pix_code: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_PIXEL) |-> (code_ff == ERR_NONE))
      else $error("pixel word carries an error code");

   a_pix_state: assert property (@(posedge clock) disable iff (reset)
      pix_done |-> (state_ff == BK_PIXELS && pad_ff == 2'd0))
      else $error("pixel completed outside pixel data");

   a_rgb_alpha: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_PIXEL && !has_alpha_ff) |-> (alpha_ff == 8'd0))
      else $error("alpha set on 24-bit pixel");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE && !(pop && head_token.eof)) |=> (state_ff == BK_DONE))
      else $error("left finished image before end of file");

endmodule

### sv/bmp_uncompressed_pixel_decoder_core.sv
// Uncompressed 24/32-bit BMP pixel decoder.
// The req_ channel takes the file one byte per word (req_data_byte, with
// req_end_of_file on the last byte). The header is parsed on the fly; byte 53
// decides between unsupported (error 2) and pixel decoding. Each completed
// pixel leaves on the rsp_ channel as one word with column, top-down row and
// R, G, B, A; short headers and truncated data leave as one error word.
// Throughput: one byte per cycle while the queue is not full. A pixel word
// passes from the front parser into the four-entry token queue and then
// through the back assembler's output register. The queue lets the parser
// keep taking bytes while a result waits under rsp_stall; req_stall rises
// only when the queue is full, so a stalled receiver holds the input after
// at most four pending tokens.
// Bytes that produce no token (header, skip, drain of a rejected file) never
// wait on rsp_stall unless the queue is full.
// Reset (synchronous, active high) empties the queue, drops any pending word
// and returns the parser to the start of a file; the end-of-file byte does
// the same for the parser state after it is taken.
module bmp_uncompressed_pixel_decoder_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_error_code,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_has_alpha,
   output logic        rsp_last_pixel
);
   import bupd_pkg::*;

   logic      push;
   token_type push_token;
   logic      q_full;
   logic      head_valid;
   token_type head_token;
   logic      pop;

   assign req_stall = q_full;

   bupd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .push            (push),
      .push_token      (push_token)
   );

   bupd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   bupd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_token      (head_token),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_error_code  (rsp_error_code),
      .rsp_column      (rsp_column),
      .rsp_row         (rsp_row),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_has_alpha   (rsp_has_alpha),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import bupd_pkg::*;

   localparam int OFFSET_AT    = 10;
   localparam int WIDTH_AT     = 18;
   localparam int HEIGHT_AT    = 22;
   localparam int PLANES_AT    = 26;
   localparam int BITS_AT      = 28;
   localparam int COMP_AT      = 30;
   localparam int MAX_DIM      = 4096;
   localparam int QUIET_LIMIT  = 3000;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic [2:0] {
      DEC_HEADER,
      DEC_SKIP,
      DEC_PIXELS,
      DEC_DONE,
      DEC_DRAIN
   } decode_phase_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  code;
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  red, green, blue, alpha;
      logic        has_alpha;
      logic        last;
   } pixel_word_type;

   class pixel_scoreboard_type;
      decode_phase_type phase;
      logic [31:0]      pos, data_offset, width, height, column, file_row;
      logic             plane_ok, bits24, bits32, comp_ok;
      int               byte_in_pixel, padding_left;
      logic [23:0]      gathered;
      pixel_word_type   expected_words[$];
      int               failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         phase = DEC_HEADER;
         pos = '0;
         data_offset = '0;
         width = '0;
         height = '0;
         column = '0;
         file_row = '0;
         plane_ok = 1'b0;
         bits24 = 1'b0;
         bits32 = 1'b0;
         comp_ok = 1'b0;
         byte_in_pixel = 0;
         padding_left = 0;
         gathered = '0;
      endfunction

      function pixel_word_type error_word(logic [1:0] code);
         pixel_word_type w;
         w = '0;
         w.kind = KIND_ERROR;
         w.code = code;
         return w;
      endfunction

      function string describe(pixel_word_type w);
         return $sformatf({"kind=%0d code=%0d col=%0d row=%0d ",
                           "rgba=%02h_%02h_%02h_%02h a=%0d last=%0d"},
                          w.kind, w.code, w.column, w.row, w.red, w.green, w.blue, w.alpha,
                          w.has_alpha, w.last);
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%s", msg);
      endfunction

      function int words_outstanding();
         return expected_words.size();
      endfunction

      // Advance the decoder by one accepted file byte.
      function void take_byte(logic [7:0] b, logic eof);
         pixel_word_type w;
         logic           emit, finished, last, ok;
         logic [31:0]    bpp;
         w = '0;
         emit = 1'b0;
         finished = 1'b0;
         bpp = bits32 ? 32'd4 : 32'd3;
         case (phase)
            DEC_HEADER: begin
               if (pos >= OFFSET_AT && pos < OFFSET_AT + 4)
                  data_offset |= 32'(b) << (8 * (pos - OFFSET_AT));
               else if (pos >= WIDTH_AT && pos < WIDTH_AT + 4)
                  width |= 32'(b) << (8 * (pos - WIDTH_AT));
               else if (pos >= HEIGHT_AT && pos < HEIGHT_AT + 4)
                  height |= 32'(b) << (8 * (pos - HEIGHT_AT));
               else if (pos == PLANES_AT) begin
                  if (b == 8'd1) plane_ok = 1'b1;
               end else if (pos == PLANES_AT + 1) begin
                  if (b != 8'd0) plane_ok = 1'b0;
               end else if (pos == BITS_AT) begin
                  if (b == 8'd24) bits24 = 1'b1;
                  if (b == 8'd32) bits32 = 1'b1;
               end else if (pos == BITS_AT + 1) begin
                  if (b != 8'd0) begin
                     bits24 = 1'b0;
                     bits32 = 1'b0;
                  end
               end else if (pos == COMP_AT) begin
                  if (b == 8'd0) comp_ok = 1'b1;
               end else if (pos > COMP_AT && pos < COMP_AT + 4) begin
                  if (b != 8'd0) comp_ok = 1'b0;
               end
               if (pos == HDR_LAST) begin
                  ok = plane_ok && comp_ok && (bits24 || bits32) &&
                       width >= 1 && width <= MAX_DIM && height >= 1 && height <= MAX_DIM;
                  if (!ok) begin
                     w = error_word(ERR_UNSUP);
                     emit = 1'b1;
                     phase = DEC_DRAIN;
                  end else begin
                     phase = (data_offset > PIXEL_START) ? DEC_SKIP : DEC_PIXELS;
                     if (eof) begin
                        w = error_word(ERR_TRUNC);
                        emit = 1'b1;
                     end
                  end
               end else if (eof) begin
                  w = error_word(ERR_SHORT);
                  emit = 1'b1;
               end
            end
            DEC_SKIP: begin
               if (pos + 32'd1 >= data_offset || pos == '1)
                  phase = DEC_PIXELS;
               if (eof) begin
                  w = error_word(ERR_TRUNC);
                  emit = 1'b1;
               end
            end
            DEC_PIXELS: begin
               if (padding_left != 0) begin
                  padding_left--;
               end else begin
                  if (byte_in_pixel < 3)
                     gathered |= 24'(b) << (8 * byte_in_pixel);
                  byte_in_pixel++;
                  if (byte_in_pixel >= bpp) begin
                     last = (column + 32'd1 >= width) && (file_row + 32'd1 >= height);
                     w.kind = KIND_PIXEL;
                     w.code = ERR_NONE;
                     w.column = column[11:0];
                     w.row = 12'(height - 32'd1 - file_row);
                     w.red = gathered[23:16];
                     w.green = gathered[15:8];
                     w.blue = gathered[7:0];
                     w.alpha = (bpp == 32'd4) ? b : 8'd0;
                     w.has_alpha = (bpp == 32'd4);
                     w.last = last;
                     emit = 1'b1;
                     byte_in_pixel = 0;
                     gathered = '0;
                     if (last) begin
                        phase = DEC_DONE;
                        finished = 1'b1;
                     end else if (column + 32'd1 >= width) begin
                        column = '0;
                        file_row++;
                        padding_left = int'((32'd4 - ((width * bpp) & 32'd3)) & 32'd3);
                     end else begin
                        column++;
                     end
                  end
               end
               // a truncating end of file replaces the pixel it would complete
               if (eof && !finished) begin
                  w = error_word(ERR_TRUNC);
                  emit = 1'b1;
               end
            end
            default: ;
         endcase
         if (pos != '1)
            pos++;
         if (eof)
            restart();
         if (emit)
            expected_words.push_back(w);
      endfunction

      function void check_word(pixel_word_type got);
         pixel_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word: %s", describe(got)));
         end else begin
            want = expected_words.pop_front();
            if (got !== want)
               report($sformatf("mismatch: expected %s, got %s", describe(want), describe(got)));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_end_of_file;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_result_kind;
   logic [1:0]  rsp_error_code;
   logic [11:0] rsp_column;
   logic [11:0] rsp_row;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic        rsp_has_alpha;
   logic        rsp_last_pixel;

   pixel_scoreboard_type sb = new();
   logic [7:0]           file_bytes[$];
   int                   bytes_sent = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   stall_hold_cycles = 0;

   always #4 clock = ~clock;

   bmp_uncompressed_pixel_decoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_error_code  (rsp_error_code),
      .rsp_column      (rsp_column),
      .rsp_row         (rsp_row),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_has_alpha   (rsp_has_alpha),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   always @(posedge clock) begin : monitor
      pixel_word_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.take_byte(req_data_byte, req_end_of_file);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_result_kind, rsp_error_code, rsp_column, rsp_row, rsp_red, rsp_green,
                   rsp_blue, rsp_alpha, rsp_has_alpha, rsp_last_pixel};
            sb.check_word(got);
         end
      end
   end

   // Hold off for a requested stretch, otherwise stall at random.
   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_hold_cycles > 0) begin
            stall_hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb NOT OK");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Send the file image, cut short to the given length if it is non-zero.
   task automatic send_file(input int cut);
      int n;
      n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(file_bytes[i], i == n - 1);
      bytes_sent += n;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.words_outstanding() != 0);
   endtask

   task automatic put_le(input int at, input logic [31:0] value, input int len);
      for (int i = 0; i < len; i++)
         file_bytes[at + i] = value[8*i +: 8];
   endtask

   task automatic add_random(input int n);
      repeat (n) file_bytes.push_back(8'($urandom));
   endtask

   task automatic build_header(input logic [31:0] offset, width, height,
                               input logic [15:0] planes, bits,
                               input logic [31:0] comp);
      file_bytes.delete();
      add_random(int'(PIXEL_START));
      put_le(OFFSET_AT, offset, 4);
      put_le(WIDTH_AT, width, 4);
      put_le(HEIGHT_AT, height, 4);
      put_le(PLANES_AT, 32'(planes), 2);
      put_le(BITS_AT, 32'(bits), 2);
      put_le(COMP_AT, comp, 4);
   endtask

   task automatic send_random_file();
      int pick, w, h, bits, bpp, off, body, cut;
      pick = $urandom_range(99);
      cut = 0;
      if (pick < 75) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
         h = $urandom_range(3, 1);
         bits = $urandom_range(1) ? 32 : 24;
         bpp = bits / 8;
         case ($urandom_range(2))
            0:       off = $urandom_range(54);
            1:       off = 54;
            default: off = $urandom_range(66, 55);
         endcase
         build_header(off, w, h, 16'd1, 16'(bits), 32'd0);
         body = (off > 54 ? off - 54 : 0) + h * (w * bpp + (4 - (w * bpp) % 4) % 4) +
                $urandom_range(4);
         add_random(body);
         if ($urandom_range(9) == 0)
            cut = $urandom_range(file_bytes.size() - 1, 54);
      end else if (pick < 90) begin
         build_header($urandom_range(60), $urandom_range(4, 1), $urandom_range(3, 1),
                      16'd1, 16'd24, 32'd0);
         case ($urandom_range(5))
            0: put_le(PLANES_AT, $urandom_range(65535), 2);
            1: put_le(BITS_AT, $urandom_range(65535), 2);
            2: file_bytes[COMP_AT + $urandom_range(3)] = 8'($urandom_range(255, 1));
            3: put_le(WIDTH_AT, $urandom_range(1) ? 32'd0 : $urandom, 4);
            4: put_le(HEIGHT_AT, $urandom_range(1) ? 32'd0 : ($urandom | 32'h8000_0000), 4);
            default: put_le(WIDTH_AT, MAX_DIM + 1 + $urandom_range(100), 4);
         endcase
         add_random($urandom_range(12));
      end else begin
         file_bytes.delete();
         add_random($urandom_range(60, 1));
      end
      send_file(cut);
   endtask

   task automatic run_random(input int target);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < target) begin
         send_random_file();
         if ($urandom_range(4) == 0)
            wait_drained();
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      req_end_of_file = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 29;
      recv_idle_pct = 63;

      // short headers: end of file on the first byte and part-way in
      file_bytes.delete();
      file_bytes.push_back(8'hff);
      send_file(0);
      build_header(54, 1, 1, 16'd1, 16'd24, 32'd0);
      send_file(20);
      // good header ending on its last byte
      build_header(54, 2, 2, 16'd1, 16'd24, 32'd0);
      send_file(54);
      // unsupported formats, drained to end of file
      build_header(54, 2, 1, 16'd1, 16'd16, 32'd0);
      add_random(8);
      send_file(0);
      build_header(54, 0, 1, 16'd1, 16'd24, 32'd0);
      send_file(54);
      build_header(54, MAX_DIM + 1, 1, 16'd1, 16'd32, 32'd0);
      add_random(4);
      send_file(0);
      build_header(54, 1, 32'hffff_fffe, 16'd1, 16'd24, 32'd0);
      send_file(0);
      build_header(54, 32'h0100_0001, 1, 16'd1, 16'd24, 32'd0);
      send_file(0);
      build_header(54, 1, 1, 16'd2, 16'd24, 32'd0);
      send_file(0);
      build_header(54, 1, 1, 16'd1, 16'd24, 32'h0100_0000);
      send_file(0);
      // offset below the header, pixel extremes, trailing bytes ignored
      build_header(0, 1, 1, 16'd1, 16'd24, 32'd0);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hff);
      file_bytes.push_back(8'h80);
      add_random(3);
      send_file(0);
      // skip ahead to the data, then a padded 24-bit image
      build_header(60, 3, 2, 16'd1, 16'd32, 32'd0);
      add_random(6 + 24);
      send_file(0);
      build_header(55, 2, 2, 16'd1, 16'd24, 32'd0);
      add_random(1 + 16);
      send_file(0);
      // largest image, cut in the middle of a pixel
      build_header(54, MAX_DIM, MAX_DIM, 16'd1, 16'd32, 32'd0);
      add_random(14);
      send_file(0);
      // huge offset, cut during the skip
      build_header(32'hffff_ff00, 1, 1, 16'd1, 16'd24, 32'd0);
      add_random(5);
      send_file(0);
      // end of file on the final pixel, and on a pixel before the final one
      build_header(54, 1, 1, 16'd1, 16'd32, 32'd0);
      repeat (4) file_bytes.push_back(8'hff);
      send_file(0);
      build_header(54, 2, 1, 16'd1, 16'd24, 32'd0);
      add_random(3);
      send_file(0);
      wait_drained();

      run_random(80);

      send_idle_pct = 63;
      recv_idle_pct = 29;
      run_random(80);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // hold the receiver long enough for the block to fill and stall its input
      wait_drained();
      @(posedge clock);
      stall_hold_cycles = 160;
      @(negedge clock);
      build_header(54, 8, 4, 16'd1, 16'd32, 32'd0);
      add_random(128);
      send_file(0);
      wait_drained();
      run_random(80);

      wait_drained();
      repeat (12) @(negedge clock);
      if (sb.failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

### sim.f
sv/bupd_pkg.sv
sv/bupd_front.sv
sv/bupd_queue.sv
sv/bupd_back.sv
sv/bmp_uncompressed_pixel_decoder_core.sv
dv/tb.sv
